@@ hw/rtl/csl_pkg.sv @@
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types, codes and character tables for the C subset lexer.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int TOKEN_LIMIT = 32;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [5:0] kind;
    logic [7:0] ch;
    logic       valid;
    logic       last;
  } res_t;

  // lexer modes
  localparam logic [3:0] M_IDLE          = 4'd0;
  localparam logic [3:0] M_NAME          = 4'd1;
  localparam logic [3:0] M_NUMBER        = 4'd2;
  localparam logic [3:0] M_STR           = 4'd3;
  localparam logic [3:0] M_STR_HELD      = 4'd4;
  localparam logic [3:0] M_STR_ESC       = 4'd5;
  localparam logic [3:0] M_STR_ESC_HELD  = 4'd6;
  localparam logic [3:0] M_CHR_OPEN      = 4'd7;
  localparam logic [3:0] M_CHR_ESC       = 4'd8;
  localparam logic [3:0] M_CHR_CLOSE     = 4'd9;
  localparam logic [3:0] M_CHR_CLOSE_ESC = 4'd10;
  localparam logic [3:0] M_OP            = 4'd11;
  localparam logic [3:0] M_SKIP          = 4'd12;

  // sequencer phases
  localparam logic [2:0] P_IDLE  = 3'd0;
  localparam logic [2:0] P_BYTE  = 3'd1;
  localparam logic [2:0] P_START = 3'd2;
  localparam logic [2:0] P_NULFL = 3'd3;
  localparam logic [2:0] P_NULSK = 3'd4;
  localparam logic [2:0] P_EOL   = 3'd5;
  localparam logic [2:0] P_DRAIN = 3'd6;
  localparam logic [2:0] P_PAIR2 = 3'd7;

  localparam logic [5:0] K_NAME   = 6'd0;
  localparam logic [5:0] K_NUMBER = 6'd1;
  localparam logic [5:0] K_STRING = 6'd2;
  localparam logic [5:0] K_CHAR   = 6'd3;
  localparam logic [5:0] K_KW0    = 6'd4;
  localparam logic [5:0] K_OTHER  = 6'd50;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  function automatic logic is_alpha(input logic [7:0] c);
    return c == CH_USCORE || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0A;
  endfunction

  function automatic logic may_pair(input logic [7:0] c);
    return c == "+" || c == "-" || c == "&" || c == "|" || c == "=" ||
           c == ">" || c == "<" || c == "!" || c == CH_SLASH;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "*":     k = 6'd20;
      "/":     k = 6'd21;
      "{":     k = 6'd22;
      "}":     k = 6'd23;
      ";":     k = 6'd24;
      ".":     k = 6'd25;
      "(":     k = 6'd26;
      ")":     k = 6'd27;
      ",":     k = 6'd28;
      "[":     k = 6'd29;
      "]":     k = 6'd30;
      ":":     k = 6'd31;
      "?":     k = 6'd32;
      "+":     k = 6'd34;
      "-":     k = 6'd37;
      "&":     k = 6'd39;
      "|":     k = 6'd41;
      "=":     k = 6'd43;
      ">":     k = 6'd45;
      "<":     k = 6'd47;
      "!":     k = 6'd49;
      default: k = K_OTHER;
    endcase
    return k;
  endfunction

  // pair kind, zero when the two bytes form no operator
  function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
    logic [5:0] k;
    k = 6'd0;
    if (p == "+" && c == "+") k = 6'd33;
    if (p == "-" && c == ">") k = 6'd35;
    if (p == "-" && c == "-") k = 6'd36;
    if (p == "&" && c == "&") k = 6'd38;
    if (p == "|" && c == "|") k = 6'd40;
    if (p == "=" && c == "=") k = 6'd42;
    if (p == ">" && c == "=") k = 6'd44;
    if (p == "<" && c == "=") k = 6'd46;
    if (p == "!" && c == "=") k = 6'd48;
    return k;
  endfunction

  function automatic logic [7:0] decode_escape(input logic [7:0] c);
    logic [7:0] d;
    case (c)
      "n":     d = 8'd10;
      "t":     d = 8'd9;
      "0":     d = 8'd0;
      default: d = c;
    endcase
    return d;
  endfunction

  function automatic logic [63:0] kw_str(input logic [3:0] k);
    logic [63:0] s;
    case (k)
      4'd0:    s = "int";
      4'd1:    s = "if";
      4'd2:    s = "while";
      4'd3:    s = "return";
      4'd4:    s = "void";
      4'd5:    s = "else";
      4'd6:    s = "struct";
      4'd7:    s = "sizeof";
      4'd8:    s = "typedef";
      4'd9:    s = "for";
      4'd10:   s = "switch";
      4'd11:   s = "case";
      4'd12:   s = "default";
      4'd13:   s = "break";
      4'd14:   s = "char";
      default: s = "enum";
    endcase
    return s;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    logic [3:0] n;
    case (k)
      4'd0, 4'd9:                    n = 4'd3;
      4'd1:                          n = 4'd2;
      4'd2, 4'd13:                   n = 4'd5;
      4'd3, 4'd6, 4'd7, 4'd10:       n = 4'd6;
      4'd8, 4'd12:                   n = 4'd7;
      default:                       n = 4'd4;
    endcase
    return n;
  endfunction

  // character at position p (p below kw_len)
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
    logic [63:0] s;
    logic [3:0]  sh;
    s  = kw_str(k);
    sh = kw_len(k) - 4'd1 - {1'b0, p};
    return s[{sh[2:0], 3'b000} +: 8];
  endfunction

endpackage

@@ hw/rtl/csl_front.sv @@
// ----------------------------------------------------------------------------
// csl_front
// Takes source bytes and steps the lexer, pushing at most one result per step.
// ----------------------------------------------------------------------------
module csl_front #(
  parameter int TokenLimit = csl_pkg::TOKEN_LIMIT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_source_byte,
  input  logic              in_line_end,
  output logic              push_en,
  output csl_pkg::res_t     push_data,
  input  logic              q_full
);

  localparam int IW = (TokenLimit > 1) ? $clog2(TokenLimit) : 1;
  localparam logic [5:0] LIM = 6'(TokenLimit);

  logic [2:0]  phase_r, phase_nxt, ret_r, ret_nxt;
  logic [3:0]  mode_r, mode_nxt;
  logic [7:0]  c_r, c_nxt, pend_r, pend_nxt;
  logic        eol_r, eol_nxt;
  logic [5:0]  wlen_r, wlen_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [15:0] mask_r, mask_nxt;
  logic [7:0]  buf_r [TokenLimit];

  logic          buf_we;
  logic [IW-1:0] buf_wa;
  logic [2:0]    after;
  logic          do_start, do_flush, app, app_first;
  logic [2:0]    flush_cont, app_cont;
  logic [5:0]    pos;
  logic [15:0]   mbase;
  logic [5:0]    word_kind;
  logic [5:0]    pk;

  assign in_stall = (phase_r != csl_pkg::P_IDLE);
  assign after    = eol_r ? csl_pkg::P_EOL : csl_pkg::P_IDLE;
  assign pk       = csl_pkg::pair_kind(pend_r, c_r);

  always_comb begin
    word_kind = csl_pkg::K_NAME;
    if (mode_r == csl_pkg::M_NUMBER) begin
      word_kind = csl_pkg::K_NUMBER;
    end else begin
      for (int k = 15; k >= 0; k--) begin
        if (mask_r[k] && wlen_r == {2'b00, csl_pkg::kw_len(4'(k))}) begin
          word_kind = csl_pkg::K_KW0 + 6'(k);
        end
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    ret_nxt   = ret_r;
    mode_nxt  = mode_r;
    c_nxt     = c_r;
    eol_nxt   = eol_r;
    pend_nxt  = pend_r;
    wlen_nxt  = wlen_r;
    idx_nxt   = idx_r;
    mask_nxt  = mask_r;
    push_en   = 1'b0;
    push_data = '0;
    buf_we    = 1'b0;
    buf_wa    = '0;
    do_start  = 1'b0;
    do_flush  = 1'b0;
    app       = 1'b0;
    app_first = 1'b0;
    flush_cont = csl_pkg::P_IDLE;
    app_cont  = csl_pkg::P_IDLE;
    pos       = '0;
    mbase     = '0;

    if (phase_r == csl_pkg::P_IDLE) begin
      if (in_valid) begin
        c_nxt     = in_source_byte;
        eol_nxt   = in_line_end;
        phase_nxt = (in_source_byte == 8'd0) ? csl_pkg::P_NULFL : csl_pkg::P_BYTE;
      end
    end else if (!q_full) begin
      case (phase_r)
        csl_pkg::P_BYTE: begin
          phase_nxt = after;
          case (mode_r)
            csl_pkg::M_NAME, csl_pkg::M_NUMBER: begin
              if (csl_pkg::is_digit(c_r) ||
                  (mode_r == csl_pkg::M_NAME && csl_pkg::is_alpha(c_r))) begin
                app      = 1'b1;
                app_cont = after;
              end else begin
                phase_nxt = csl_pkg::P_DRAIN;
                idx_nxt   = '0;
                ret_nxt   = csl_pkg::P_START;
              end
            end
            csl_pkg::M_OP: begin
              if (pend_r == csl_pkg::CH_SLASH && c_r == csl_pkg::CH_SLASH) begin
                mode_nxt = csl_pkg::M_SKIP;
              end else if (pk != 6'd0) begin
                push_en   = 1'b1;
                push_data = '{kind: pk, ch: pend_r, valid: 1'b1, last: 1'b0};
                phase_nxt = csl_pkg::P_PAIR2;
              end else begin
                push_en   = 1'b1;
                push_data = '{kind: csl_pkg::single_kind(pend_r), ch: pend_r,
                              valid: 1'b1, last: 1'b1};
                mode_nxt  = csl_pkg::M_IDLE;
                phase_nxt = csl_pkg::P_START;
              end
            end
            csl_pkg::M_STR, csl_pkg::M_STR_HELD: begin
              if (c_r == csl_pkg::CH_DQUOTE) begin
                do_flush   = 1'b1;
                flush_cont = after;
              end else if (c_r == csl_pkg::CH_BSLASH) begin
                mode_nxt = (mode_r == csl_pkg::M_STR) ? csl_pkg::M_STR_ESC
                                                     : csl_pkg::M_STR_ESC_HELD;
              end else begin
                if (mode_r == csl_pkg::M_STR_HELD) begin
                  push_en   = 1'b1;
                  push_data = '{kind: csl_pkg::K_STRING, ch: pend_r, valid: 1'b1, last: 1'b0};
                end
                pend_nxt = c_r;
                mode_nxt = csl_pkg::M_STR_HELD;
              end
            end
            csl_pkg::M_STR_ESC, csl_pkg::M_STR_ESC_HELD: begin
              if (mode_r == csl_pkg::M_STR_ESC_HELD) begin
                push_en   = 1'b1;
                push_data = '{kind: csl_pkg::K_STRING, ch: pend_r, valid: 1'b1, last: 1'b0};
              end
              pend_nxt = csl_pkg::decode_escape(c_r);
              mode_nxt = csl_pkg::M_STR_HELD;
            end
            csl_pkg::M_CHR_OPEN: begin
              if (c_r == csl_pkg::CH_BSLASH) begin
                mode_nxt = csl_pkg::M_CHR_ESC;
              end else begin
                push_en   = 1'b1;
                push_data = '{kind: csl_pkg::K_CHAR, ch: c_r, valid: 1'b1, last: 1'b1};
                mode_nxt  = csl_pkg::M_CHR_CLOSE;
              end
            end
            csl_pkg::M_CHR_ESC: begin
              push_en   = 1'b1;
              push_data = '{kind: csl_pkg::K_CHAR, ch: csl_pkg::decode_escape(c_r),
                            valid: 1'b1, last: 1'b1};
              mode_nxt  = csl_pkg::M_CHR_CLOSE;
            end
            csl_pkg::M_CHR_CLOSE: begin
              mode_nxt = (c_r == csl_pkg::CH_BSLASH) ? csl_pkg::M_CHR_CLOSE_ESC
                                                    : csl_pkg::M_IDLE;
            end
            csl_pkg::M_CHR_CLOSE_ESC: mode_nxt = csl_pkg::M_IDLE;
            csl_pkg::M_SKIP: ;
            default: do_start = 1'b1;
          endcase
        end
        csl_pkg::P_START: do_start = 1'b1;
        csl_pkg::P_NULFL: begin
          do_flush   = 1'b1;
          flush_cont = csl_pkg::P_NULSK;
        end
        csl_pkg::P_NULSK: begin
          mode_nxt  = csl_pkg::M_SKIP;
          phase_nxt = after;
        end
        csl_pkg::P_EOL: begin
          do_flush   = 1'b1;
          flush_cont = csl_pkg::P_IDLE;
        end
        csl_pkg::P_PAIR2: begin
          push_en   = 1'b1;
          push_data = '{kind: pk, ch: c_r, valid: 1'b1, last: 1'b1};
          mode_nxt  = csl_pkg::M_IDLE;
          phase_nxt = after;
        end
        csl_pkg::P_DRAIN: begin
          push_en   = 1'b1;
          push_data = '{kind: word_kind, ch: buf_r[idx_r], valid: 1'b1,
                        last: (6'(idx_r) + 6'd1 == wlen_r)};
          if (6'(idx_r) + 6'd1 == wlen_r) begin
            wlen_nxt  = '0;
            mode_nxt  = csl_pkg::M_IDLE;
            phase_nxt = ret_r;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
        default: phase_nxt = csl_pkg::P_IDLE;
      endcase

      if (do_start) begin
        mode_nxt  = csl_pkg::M_IDLE;
        phase_nxt = after;
        if (csl_pkg::is_space(c_r)) begin
          mode_nxt = csl_pkg::M_IDLE;
        end else if (c_r == csl_pkg::CH_HASH) begin
          mode_nxt = csl_pkg::M_SKIP;
        end else if (csl_pkg::is_alpha(c_r) || csl_pkg::is_digit(c_r)) begin
          mode_nxt  = csl_pkg::is_digit(c_r) ? csl_pkg::M_NUMBER : csl_pkg::M_NAME;
          app       = 1'b1;
          app_first = 1'b1;
          app_cont  = after;
        end else if (c_r == csl_pkg::CH_DQUOTE) begin
          mode_nxt = csl_pkg::M_STR;
        end else if (c_r == csl_pkg::CH_SQUOTE) begin
          mode_nxt = csl_pkg::M_CHR_OPEN;
        end else if (csl_pkg::may_pair(c_r)) begin
          pend_nxt = c_r;
          mode_nxt = csl_pkg::M_OP;
        end else begin
          push_en   = 1'b1;
          push_data = '{kind: csl_pkg::single_kind(c_r), ch: c_r, valid: 1'b1, last: 1'b1};
        end
      end

      if (do_flush) begin
        mode_nxt  = csl_pkg::M_IDLE;
        phase_nxt = flush_cont;
        case (mode_r)
          csl_pkg::M_NAME, csl_pkg::M_NUMBER: begin
            mode_nxt  = mode_r;
            phase_nxt = csl_pkg::P_DRAIN;
            idx_nxt   = '0;
            ret_nxt   = flush_cont;
          end
          csl_pkg::M_OP: begin
            push_en   = 1'b1;
            push_data = '{kind: csl_pkg::single_kind(pend_r), ch: pend_r,
                          valid: 1'b1, last: 1'b1};
          end
          csl_pkg::M_STR, csl_pkg::M_STR_ESC: begin
            push_en   = 1'b1;
            push_data = '{kind: csl_pkg::K_STRING, ch: 8'd0, valid: 1'b0, last: 1'b1};
          end
          csl_pkg::M_STR_HELD, csl_pkg::M_STR_ESC_HELD: begin
            push_en   = 1'b1;
            push_data = '{kind: csl_pkg::K_STRING, ch: pend_r, valid: 1'b1, last: 1'b1};
          end
          csl_pkg::M_CHR_OPEN, csl_pkg::M_CHR_ESC: begin
            push_en   = 1'b1;
            push_data = '{kind: csl_pkg::K_CHAR, ch: 8'd0, valid: 1'b0, last: 1'b1};
          end
          default: ;
        endcase
      end

      if (app) begin
        pos    = app_first ? 6'd0 : wlen_r;
        mbase  = app_first ? 16'hFFFF : mask_r;
        buf_we = 1'b1;
        buf_wa = pos[IW-1:0];
        wlen_nxt = pos + 6'd1;
        for (int k = 0; k < 16; k++) begin
          mask_nxt[k] = mbase[k] && (pos < {2'b00, csl_pkg::kw_len(4'(k))}) &&
                        (csl_pkg::kw_char(4'(k), pos[2:0]) == c_r);
        end
        if (pos + 6'd1 >= LIM) begin
          phase_nxt = csl_pkg::P_DRAIN;
          idx_nxt   = '0;
          ret_nxt   = app_cont;
        end else begin
          phase_nxt = app_cont;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= csl_pkg::P_IDLE;
      ret_r   <= csl_pkg::P_IDLE;
      mode_r  <= csl_pkg::M_IDLE;
      wlen_r  <= '0;
      pend_r  <= '0;
      idx_r   <= '0;
      mask_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      ret_r   <= ret_nxt;
      mode_r  <= mode_nxt;
      wlen_r  <= wlen_nxt;
      pend_r  <= pend_nxt;
      idx_r   <= idx_nxt;
      mask_r  <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r   <= c_nxt;
    eol_r <= eol_nxt;
    if (buf_we) begin
      buf_r[buf_wa] <= c_r;
    end
  end

  a_wlen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wlen_r <= LIM) else $error("word length beyond limit");
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == csl_pkg::P_DRAIN |-> wlen_r != 6'd0) else $error("drain of empty word");
  a_op_pend: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == csl_pkg::M_OP |-> csl_pkg::may_pair(pend_r)) else $error("bad pending op");

endmodule

@@ hw/rtl/csl_emit.sv @@
// ----------------------------------------------------------------------------
// csl_emit
// Result queue between the lexer sequencer and the output channel.
// ----------------------------------------------------------------------------
module csl_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_en,
  input  csl_pkg::res_t push_data,
  output logic          q_full,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [5:0]    out_token_kind,
  output logic [7:0]    out_text_char,
  output logic          out_char_valid,
  output logic          out_token_last
);

  localparam int D  = csl_pkg::QUEUE_DEPTH;
  localparam int AW = $clog2(D);

  csl_pkg::res_t  mem_r [D];
  logic [AW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;
  logic           pop, push;
  csl_pkg::res_t  head;

  assign q_full    = (cnt_r == (AW+1)'(D));
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign push      = push_en && !q_full;
  assign head      = mem_r[rp_r];

  assign out_token_kind = head.kind;
  assign out_text_char  = head.ch;
  assign out_char_valid = head.valid;
  assign out_token_last = head.last;

  always_comb begin
    wp_nxt  = push ? wp_r + AW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + AW'(1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push_en |-> !q_full) else $error("push into full queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(D)) else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r == AW'(rp_r + cnt_r[AW-1:0])) else $error("queue pointers disagree");

endmodule

@@ hw/rtl/c_subset_lexer.sv @@
// ----------------------------------------------------------------------------
// c_subset_lexer
// Streaming tokenizer for a subset of C, one source byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one source byte per transaction,
//   in_line_end marking the last byte of a line. Output channel
//   (out_valid / out_stall): one token character per transaction, with its
//   kind, char_valid and a last flag on the final character of the token.
// Timing:
//   The front takes a byte only when its sequencer is idle, then runs one
//   step per cycle while the result queue has space, each step pushing at
//   most one result. A plain byte is a single step, and no new byte is
//   taken until its steps are done. Extra steps: the second character of a
//   two-character operator, the restart after an operator or a word that a
//   byte ends, one per character of a word as it drains from the word
//   buffer, the line-end flush, and the flush and skip steps for a NUL.
//   A result is valid on the cycle after the step that pushed it.
// Reset:
//   rst_n (synchronous, active low) returns the lexer to idle and empties
//   the result queue; the word buffer holds stale data that is never read.
// Stall:
//   A stalled output fills the 4-entry result queue; the sequencer then
//   pauses and in_stall stays high until space is freed. No result is lost.
// ----------------------------------------------------------------------------
module c_subset_lexer #(
  parameter int TokenLimit = csl_pkg::TOKEN_LIMIT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_source_byte,
  input  logic       in_line_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_token_kind,
  output logic [7:0] out_text_char,
  output logic       out_char_valid,
  output logic       out_token_last
);

  // front to queue
  logic          push_en;
  csl_pkg::res_t push_data;
  logic          q_full;

  csl_front #(.TokenLimit(TokenLimit)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_source_byte (in_source_byte),
    .in_line_end    (in_line_end),
    .push_en        (push_en),
    .push_data      (push_data),
    .q_full         (q_full)
  );

  // back: queue and output port
  csl_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .push_en        (push_en),
    .push_data      (push_data),
    .q_full         (q_full),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_token_kind (out_token_kind),
    .out_text_char  (out_text_char),
    .out_char_valid (out_char_valid),
    .out_token_last (out_token_last)
  );

endmodule
